@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files; only the top level includes them.
// Needs a clock and an active-low reset named by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ rtl/tsu_pkg.sv @@
// Types, codes and constants of the TIFF scanline sample unpacker.
// No dependencies.
`default_nettype none
package tsu_pkg;

  localparam int unsigned MaxRowPixels   = 4096;
  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned ByteBits       = 8;
  localparam int unsigned RgbaChannels   = 4;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned ChanW          = $clog2(RgbaChannels);

  typedef enum logic [1:0] {
    REG_SAMPLE_BITS,
    REG_PIXEL_MODE,
    REG_HAS_ALPHA,
    REG_ROW_PIXELS
  } reg_e;

  typedef enum logic [1:0] {
    MODE_MIN_BLACK,
    MODE_MIN_WHITE,
    MODE_PALETTE,
    MODE_RGB
  } mode_e;

  typedef enum logic [1:0] {
    W1,
    W2,
    W4,
    W8
  } width_e;

  typedef enum logic {
    OP_DATA,
    OP_PAL_WR
  } op_e;

  typedef struct packed {
    width_e wsel;
    mode_e  mode;
    logic   alpha;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  data_byte;
    logic [7:0]  pal_index;
    logic [15:0] pal_red;
    logic [15:0] pal_green;
    logic [15:0] pal_blue;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef struct packed {
    logic busy;
  } bstat_t;

  function automatic width_e width_sel(input logic [3:0] sb);
    case (sb)
      4'd1:    return W1;
      4'd2:    return W2;
      4'd4:    return W4;
      default: return W8;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/tsu_if.sv @@
// Channel interfaces of the unpacker: input items, result items, config writes.
// No dependencies.
`default_nettype none
interface tsu_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  data_byte;
  logic [7:0]  pal_index;
  logic [15:0] pal_red;
  logic [15:0] pal_green;
  logic [15:0] pal_blue;
  modport source(output valid, func, data_byte, pal_index, pal_red, pal_green, pal_blue,
                 input ready);
  modport sink(input valid, func, data_byte, pal_index, pal_red, pal_green, pal_blue,
               output ready);
endinterface

interface tsu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [7:0]  alpha;
  logic        row_end;
  modport source(output valid, red, green, blue, alpha, row_end, input ready);
  modport sink(input valid, red, green, blue, alpha, row_end, output ready);
endinterface

interface tsu_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/tsu_front.sv @@
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on tsu_pkg and tsu_if.
`default_nettype none
module tsu_front #(
  parameter int unsigned PALETTE_ENTRIES = tsu_pkg::PaletteEntries
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tsu_in_if.sink          in_if,
  input  logic            pop_i,
  output tsu_pkg::qhead_t head_o
);
  import tsu_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            keep, push, pop;
  item_t           item;

  always_comb begin
    item.op        = in_if.func ? OP_PAL_WR : OP_DATA;
    item.data_byte = in_if.data_byte;
    item.pal_index = in_if.pal_index;
    item.pal_red   = in_if.pal_red;
    item.pal_green = in_if.pal_green;
    item.pal_blue  = in_if.pal_blue;
  end

  // drop palette writes beyond the store
  assign keep        = !in_if.func || (32'(in_if.pal_index) < PALETTE_ENTRIES);
  assign in_if.ready = cnt_q != CntW'(QueueDepth);
  assign push        = in_if.valid && in_if.ready && keep;
  assign pop         = pop_i && (cnt_q != '0);

  assign head_o.valid = cnt_q != '0;
  assign head_o.item  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tsu_back.sv @@
// Back end: sample sequencer, rgb gathering, palette store and output register.
// Depends on tsu_pkg and tsu_if.
`default_nettype none
module tsu_back #(
  parameter int unsigned MAX_ROW_PIXELS  = tsu_pkg::MaxRowPixels,
  parameter int unsigned PALETTE_ENTRIES = tsu_pkg::PaletteEntries
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  tsu_pkg::cfg_t                          cfg_i,
  input  logic [$clog2(MAX_ROW_PIXELS + 1)-1:0]  row_i,
  input  tsu_pkg::qhead_t                        head_i,
  output logic                                   pop_o,
  output tsu_pkg::bstat_t                        stat_o,
  tsu_out_if.source                              out_if
);
  import tsu_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ROW_PIXELS + 1);
  localparam int unsigned AW   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [47:0]      pal_mem [PALETTE_ENTRIES];
  logic [47:0]      rd_q;

  logic             cur_valid_q;
  item_t            cur_q;
  logic [7:0]       sh_q;
  logic [3:0]       left_q;
  logic [ChanW-1:0] ch_q;
  logic [23:0]      part_q;
  logic [CntW-1:0]  cnt_q;

  logic             ob_valid_q, ob_pal_q, ob_end_q;
  logic [15:0]      ob_r_q, ob_g_q, ob_b_q;
  logic [7:0]       ob_a_q;

  logic [7:0]       samp, mask, shifted;
  logic [3:0]       nsamp;
  logic             is_data, emit, gather, pal_hit, end_px, finish;
  logic             ob_free, step_ok, load;
  logic [15:0]      pix_r, pix_g, pix_b;
  logic [7:0]       pix_a;
  logic [23:0]      part_d;

  always_comb begin
    case (cfg_i.wsel)
      W1: begin
        samp    = {7'b0, sh_q[7]};
        mask    = 8'h01;
        shifted = {sh_q[6:0], 1'b0};
        nsamp   = 4'd8;
      end
      W2: begin
        samp    = {6'b0, sh_q[7:6]};
        mask    = 8'h03;
        shifted = {sh_q[5:0], 2'b0};
        nsamp   = 4'd4;
      end
      W4: begin
        samp    = {4'b0, sh_q[7:4]};
        mask    = 8'h0f;
        shifted = {sh_q[3:0], 4'b0};
        nsamp   = 4'd2;
      end
      default: begin
        samp    = sh_q;
        mask    = 8'hff;
        shifted = 8'h00;
        nsamp   = 4'd1;
      end
    endcase
  end

  always_comb begin
    is_data = cur_q.op == OP_DATA;
    emit    = is_data;
    gather  = 1'b0;
    pal_hit = 1'b0;
    pix_r   = '0;
    pix_g   = '0;
    pix_b   = '0;
    pix_a   = '0;
    part_d  = part_q;
    case (cfg_i.mode)
      MODE_MIN_BLACK: pix_b = 16'(samp);
      MODE_MIN_WHITE: pix_b = 16'(mask - samp);
      MODE_PALETTE:   pal_hit = 32'(samp) < PALETTE_ENTRIES;
      MODE_RGB: begin
        if (ch_q < ChanW'(2) || (ch_q == ChanW'(2) && cfg_i.alpha)) begin
          gather = is_data;
          emit   = 1'b0;
          case (ch_q)
            ChanW'(0): part_d[23:16] = samp;
            ChanW'(1): part_d[15:8]  = samp;
            default:   part_d[7:0]   = samp;
          endcase
        end else begin
          pix_r = 16'(part_q[23:16]);
          pix_g = 16'(part_q[15:8]);
          if (ch_q == ChanW'(2)) begin
            pix_b = 16'(samp);
          end else begin
            pix_b = 16'(part_q[7:0]);
            pix_a = samp;
          end
        end
      end
      default: emit = is_data;
    endcase
  end

  assign end_px  = ({1'b0, cnt_q} + {{CntW{1'b0}}, 1'b1}) >= {1'b0, row_i};
  assign finish  = !is_data || (left_q == 4'd1) || (emit && end_px);
  assign ob_free = !ob_valid_q || out_if.ready;
  assign step_ok = cur_valid_q && (!emit || ob_free);
  assign load    = !cur_valid_q || (step_ok && finish);
  assign pop_o   = load && head_i.valid;
  assign stat_o.busy = cur_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      left_q      <= '0;
      ch_q        <= '0;
      part_q      <= '0;
      cnt_q       <= '0;
      ob_valid_q  <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= head_i.valid;
      end
      if (pop_o) begin
        left_q <= nsamp;
      end else if (step_ok) begin
        left_q <= left_q - 4'd1;
      end
      if (step_ok && emit) begin
        ch_q   <= '0;
        part_q <= '0;
        cnt_q  <= end_px ? '0 : cnt_q + CntW'(1);
      end else if (step_ok && gather) begin
        ch_q   <= ch_q + ChanW'(1);
        part_q <= part_d;
      end
      if (step_ok && emit) begin
        ob_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        ob_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i.item;
      sh_q  <= head_i.item.data_byte;
    end else if (step_ok) begin
      sh_q  <= shifted;
    end
    if (step_ok && emit) begin
      ob_pal_q <= pal_hit;
      ob_r_q   <= pix_r;
      ob_g_q   <= pix_g;
      ob_b_q   <= pix_b;
      ob_a_q   <= pix_a;
      ob_end_q <= end_px;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_ok && !is_data) begin
      pal_mem[AW'(cur_q.pal_index)] <= {cur_q.pal_red, cur_q.pal_green, cur_q.pal_blue};
    end
    if (step_ok && emit && pal_hit) begin
      rd_q <= pal_mem[AW'(samp)];
    end
  end

  assign out_if.valid   = ob_valid_q;
  assign out_if.red     = ob_pal_q ? rd_q[47:32] : ob_r_q;
  assign out_if.green   = ob_pal_q ? rd_q[31:16] : ob_g_q;
  assign out_if.blue    = ob_pal_q ? rd_q[15:0]  : ob_b_q;
  assign out_if.alpha   = ob_a_q;
  assign out_if.row_end = ob_end_q;

endmodule
`default_nettype wire

@@ rtl/tiff_scanline_sample_unpacker.sv @@
// Top level of the TIFF scanline sample unpacker: config registers, front and back.
// Depends on tsu_pkg, tsu_if, tsu_front, tsu_back and assert_macros.svh.
//
//   channel  dir  carries
//   in_if    in   data byte or palette write (func, data_byte, pal_*)
//   out_if   out  pixel (red, green, blue, alpha, row_end)
//   cfg_if   in   register write (index, data)
//
// The sample sequencer splits a data byte into 8/sample_bits samples (8-bit for other widths),
// one sample a cycle unless the output stalls, fewer when the row ends inside the byte.
// Reset restores config defaults and clears row and pixel state; the palette store keeps its contents.
// A two-item queue and the output register let input and output stall on their own.
`default_nettype none
`include "assert_macros.svh"
module tiff_scanline_sample_unpacker #(
  parameter int unsigned MAX_ROW_PIXELS  = tsu_pkg::MaxRowPixels,
  parameter int unsigned PALETTE_ENTRIES = tsu_pkg::PaletteEntries
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsu_in_if.sink     in_if,
  tsu_out_if.source  out_if,
  tsu_cfg_if.sink    cfg_if
);
  import tsu_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ROW_PIXELS + 1);

  logic [3:0]      sample_bits_q;
  mode_e           pixel_mode_q;
  logic            has_alpha_q;
  logic [12:0]     row_pixels_q;
  logic [CntW-1:0] row_eff;
  cfg_t            cfg;
  qhead_t          head;
  bstat_t          bstat;
  logic            pop;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bits_q <= 4'd8;
      pixel_mode_q  <= MODE_MIN_BLACK;
      has_alpha_q   <= 1'b0;
      row_pixels_q  <= 13'd1;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (reg_e'(cfg_if.index))
        REG_SAMPLE_BITS: sample_bits_q <= cfg_if.data[3:0];
        REG_PIXEL_MODE:  pixel_mode_q  <= mode_e'(cfg_if.data[1:0]);
        REG_HAS_ALPHA:   has_alpha_q   <= cfg_if.data[0];
        REG_ROW_PIXELS:  row_pixels_q  <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_pixels_q == '0) begin
      row_eff = CntW'(1);
    end else if (32'(row_pixels_q) > MAX_ROW_PIXELS) begin
      row_eff = CntW'(MAX_ROW_PIXELS);
    end else begin
      row_eff = CntW'(row_pixels_q);
    end
    cfg.wsel  = width_sel(sample_bits_q);
    cfg.mode  = pixel_mode_q;
    cfg.alpha = has_alpha_q;
  end

  tsu_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .pop_i  (pop),
    .head_o (head)
  );

  tsu_back #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .row_i  (row_eff),
    .head_i (head),
    .pop_o  (pop),
    .stat_o (bstat),
    .out_if (out_if)
  );

  `ASSERT_PROP(a_full_has_head, clk_i, rst_ni, !in_if.ready |-> head.valid, "queue full but empty head")
  `ASSERT_PROP(a_no_spurious_out, clk_i, rst_ni, (!head.valid && !bstat.busy && !out_if.valid) |=> !out_if.valid, "result without work")
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop && !head.valid, "pop of empty queue")

endmodule
`default_nettype wire
